/* src/psp_pkg.sv */
`default_nettype none
package psp_pkg;

    localparam int MAX_SIDE_DEF = 256;
    localparam int CFG_W        = 9;
    localparam int COORD_W      = 8;
    localparam int CELL_W       = 17;
    localparam int BYTE_W       = 8;
    localparam int S_TDATA_W    = 16;
    localparam int M_TDATA_W    = 24;

    localparam logic [BYTE_W-1:0] BYTE_ONES  = 8'hFF;
    // byte 0 with the bit for 1 already cleared
    localparam logic [BYTE_W-1:0] BYTE_FIRST = 8'hFE;

    typedef enum logic [6:0] {
        B_IDLE = 7'b0000001,
        B_FILL = 7'b0000010,
        B_PSQ  = 7'b0000100,
        B_PCHK = 7'b0001000,
        B_PBIT = 7'b0010000,
        B_MRD  = 7'b0100000,
        B_MWR  = 7'b1000000
    } build_state_t;

    typedef enum logic [5:0] {
        T_IDLE  = 6'b000001,
        T_BUILD = 6'b000010,
        T_MAP1  = 6'b000100,
        T_MAP2  = 6'b001000,
        T_ADDR  = 6'b010000,
        T_LOOK  = 6'b100000
    } top_state_t;

    typedef struct packed {
        logic busy;
        logic done;
    } build_stat_t;

endpackage
`default_nettype wire

/* src/psp_ram.sv */
`default_nettype none
module psp_ram #(
    parameter int WIDTH = psp_pkg::BYTE_W,
    parameter int DEPTH = 4096
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

/* src/psp_sieve_builder.sv */
`default_nettype none
module psp_sieve_builder #(
    parameter int MAX_SIDE  = psp_pkg::MAX_SIDE_DEF,
    parameter int RAM_DEPTH = 4096
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              start,
    input  wire logic [2*$clog2(MAX_SIDE+1)-1:0]   limit,
    output psp_pkg::build_stat_t                   stat,
    output logic                                   we,
    output logic [$clog2(RAM_DEPTH)-1:0]           waddr,
    output logic [psp_pkg::BYTE_W-1:0]             wdata,
    output logic [$clog2(RAM_DEPTH)-1:0]           raddr,
    input  wire logic [psp_pkg::BYTE_W-1:0]        rdata
);

    localparam int SIDE_W = $clog2(MAX_SIDE + 1);
    localparam int ADDR_W = $clog2(RAM_DEPTH);
    localparam int P_W    = SIDE_W + 1;
    localparam int M_W    = 2 * SIDE_W + 2;
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(RAM_DEPTH - 1);
    localparam logic [P_W-1:0]    P_FIRST   = P_W'(3);
    localparam logic [P_W-1:0]    P_STEP    = P_W'(2);
    localparam logic [M_W-1:0]    M_ONE     = M_W'(1);

    psp_pkg::build_state_t state_reg, state_next;
    logic [ADDR_W-1:0] fill_reg, fill_next;
    logic [P_W-1:0]    p_reg, p_next;
    logic [M_W-1:0]    pp_reg, pp_next;
    logic [M_W-1:0]    m_reg, m_next;
    logic [M_W-1:0]    step_reg, step_next;

    logic [M_W-1:0] lim_m, p_m1, m_m1;
    logic [2:0]     p_bit, m_bit;
    logic           done_c;

    assign lim_m = M_W'(limit);
    assign p_m1  = M_W'(p_reg) - M_ONE;
    assign m_m1  = m_reg - M_ONE;
    assign p_bit = p_m1[3:1];
    assign m_bit = m_m1[3:1];

    always_comb begin
        if (state_reg == psp_pkg::B_MRD || state_reg == psp_pkg::B_MWR) begin
            raddr = ADDR_W'(m_m1 >> 4);
        end else begin
            raddr = ADDR_W'(p_m1 >> 4);
        end
    end

    always_comb begin
        state_next = state_reg;
        fill_next  = fill_reg;
        p_next     = p_reg;
        pp_next    = pp_reg;
        m_next     = m_reg;
        step_next  = step_reg;
        we         = 1'b0;
        waddr      = fill_reg;
        wdata      = psp_pkg::BYTE_ONES;
        done_c     = 1'b0;
        unique case (state_reg)
            psp_pkg::B_IDLE: begin
                if (start) begin
                    fill_next  = '0;
                    state_next = psp_pkg::B_FILL;
                end
            end
            psp_pkg::B_FILL: begin
                we    = 1'b1;
                waddr = fill_reg;
                wdata = (fill_reg == '0) ? psp_pkg::BYTE_FIRST : psp_pkg::BYTE_ONES;
                fill_next = fill_reg + ADDR_W'(1);
                if (fill_reg == LAST_ADDR) begin
                    p_next     = P_FIRST;
                    state_next = psp_pkg::B_PSQ;
                end
            end
            psp_pkg::B_PSQ: begin
                pp_next    = M_W'(p_reg) * M_W'(p_reg);
                state_next = psp_pkg::B_PCHK;
            end
            psp_pkg::B_PCHK: begin
                if (pp_reg > lim_m) begin
                    done_c     = 1'b1;
                    state_next = psp_pkg::B_IDLE;
                end else begin
                    state_next = psp_pkg::B_PBIT;
                end
            end
            psp_pkg::B_PBIT: begin
                if (rdata[p_bit]) begin
                    m_next     = pp_reg;
                    step_next  = M_W'({p_reg, 1'b0});
                    state_next = psp_pkg::B_MRD;
                end else begin
                    p_next     = p_reg + P_STEP;
                    state_next = psp_pkg::B_PSQ;
                end
            end
            psp_pkg::B_MRD: begin
                if (m_reg > lim_m) begin
                    p_next     = p_reg + P_STEP;
                    state_next = psp_pkg::B_PSQ;
                end else begin
                    state_next = psp_pkg::B_MWR;
                end
            end
            psp_pkg::B_MWR: begin
                // read issued last cycle, write back with the multiple cleared
                we         = 1'b1;
                waddr      = ADDR_W'(m_m1 >> 4);
                wdata      = rdata & ~(psp_pkg::BYTE_W'(1) << m_bit);
                m_next     = m_reg + step_reg;
                state_next = psp_pkg::B_MRD;
            end
            default: begin
                state_next = psp_pkg::B_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= psp_pkg::B_IDLE;
        end else begin
            state_reg <= state_next;
        end
        fill_reg <= fill_next;
        p_reg    <= p_next;
        pp_reg   <= pp_next;
        m_reg    <= m_next;
        step_reg <= step_next;
    end

    assign stat.busy = (state_reg != psp_pkg::B_IDLE);
    assign stat.done = done_c;

endmodule
`default_nettype wire

/* src/psp_cell_mapper.sv */
`default_nettype none
module psp_cell_mapper #(
    parameter int MAX_SIDE = psp_pkg::MAX_SIDE_DEF
) (
    input  wire logic                                aclk,
    input  wire logic                                load,
    input  wire logic [psp_pkg::COORD_W-1:0]         row,
    input  wire logic [psp_pkg::COORD_W-1:0]         column,
    input  wire logic [$clog2(MAX_SIDE+1)-1:0]       side,
    output logic      [2*$clog2(MAX_SIDE+1)+2:0]     num,
    output logic                                     oor
);

    localparam int SIDE_W = $clog2(MAX_SIDE + 1);
    localparam int NUM_W  = 2 * SIDE_W + 3;
    localparam int CW     = (2 * SIDE_W + 4 > 10) ? 2 * SIDE_W + 4 : 10;
    localparam logic signed [CW-1:0] ONE_S = CW'(1);
    localparam logic signed [CW-1:0] TWO_S = CW'(2);

    logic [psp_pkg::COORD_W-1:0] row_reg, col_reg;
    logic [SIDE_W-1:0]           d_reg;
    logic signed [CW-1:0]        lin_a_reg, lin_b_reg;
    logic                        oor_a_reg, oor_b_reg;
    logic [2*SIDE_W-1:0]         dd_reg;

    logic signed [CW-1:0] si, sj, sn, odd_s, crow, ccol, ccen, rd, cd, dv, lin, num_s;
    logic                 lower, oor_a;

    always_comb begin
        si    = $signed(CW'(row_reg));
        sj    = $signed(CW'(col_reg));
        sn    = $signed(CW'(side));
        odd_s = $signed(CW'(side[0]));
        crow  = sn >>> 1;
        ccol  = crow - ONE_S + odd_s;
        // cells on, left of and above the anti-diagonal use the first polynomial
        lower = (si + sj) < sn;
        ccen  = lower ? ccol : ccol + ONE_S;
        rd    = (si >= crow) ? si - crow : crow - si;
        cd    = (sj >= ccen) ? sj - ccen : ccen - sj;
        dv    = (rd >= cd) ? rd : cd;
        lin   = lower ? odd_s + si - sj : (dv <<< 2) + TWO_S - odd_s + sj - si;
        oor_a = (si >= sn) || (sj >= sn);
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            row_reg <= row;
            col_reg <= column;
        end
        d_reg     <= SIDE_W'(dv);
        lin_a_reg <= lin;
        oor_a_reg <= oor_a;
        dd_reg    <= (2*SIDE_W)'(d_reg) * (2*SIDE_W)'(d_reg);
        lin_b_reg <= lin_a_reg;
        oor_b_reg <= oor_a_reg;
    end

    assign num_s = $signed(CW'({dd_reg, 2'b00})) + lin_b_reg;
    assign num   = num_s[CW-1] ? '0 : NUM_W'(num_s);
    assign oor   = oor_b_reg;

endmodule
`default_nettype wire

/* src/prime_spiral_pixel_engine.sv */
`default_nettype none
// Ulam spiral pixel engine: for one cell of a square spiral it returns the
// spiral number at that cell and whether the number is prime.
//   s_ channel: one item per cell, row and column.
//   m_ channel: one result item per input item, in order.
//   cfg channel: writes side_length; always ready, clears the sieve so the
//     next item rebuilds it. Saturated to MAX_SIDE, zero acts as one.
// The first item after reset or a configuration write starts the sieve
// build before it is accepted: a fill sweep over all sieve bytes (one byte
// a cycle, 4096 bytes at MAX_SIDE 256), then a square, bound check and bit
// test per odd candidate up to the root of side squared, a last bound check
// per prime, and a read-modify-write per cleared multiple on the single RAM.
// After the build an item passes through the accept cycle, T_MAP1 and
// T_MAP2 for the Chebyshev distance and its square, T_ADDR to present the
// sieve address and T_LOOK for the memory read, at whose end the result
// register is loaded once the output register is free. One item is
// in work at a time.
// A result waiting in the output register does not block the next accept;
// the work item then waits in the lookup step until m_tready frees it.
// Reset is synchronous, active low: side_length returns to 1, sieve marked
// not built, no result pending.
module prime_spiral_pixel_engine #(
    parameter int MAX_SIDE = psp_pkg::MAX_SIDE_DEF
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [psp_pkg::CFG_W-1:0]      cfg_data,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    // [7:0] row, [15:8] column
    input  wire logic [psp_pkg::S_TDATA_W-1:0]  s_tdata,
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    // [0] is_prime, [17:1] cell_number, [18] out_of_range, [23:19] zero
    output logic [psp_pkg::M_TDATA_W-1:0]       m_tdata
);

    localparam int SIDE_W    = $clog2(MAX_SIDE + 1);
    localparam int NUM_W     = 2 * SIDE_W + 3;
    localparam int NUMX_W    = (NUM_W > psp_pkg::CELL_W) ? NUM_W : psp_pkg::CELL_W;
    localparam int SV_BYTES  = (MAX_SIDE * MAX_SIDE - 1) / 16 + 1;
    localparam int RAM_DEPTH = (SV_BYTES < 2) ? 2 : SV_BYTES;
    localparam int ADDR_W    = $clog2(RAM_DEPTH);
    localparam int PAD_W     = psp_pkg::M_TDATA_W - psp_pkg::CELL_W - 2;

    psp_pkg::top_state_t state_reg, state_next;
    logic [psp_pkg::CFG_W-1:0]     side_reg;
    logic                          ready_reg, ready_next;
    logic [2*SIDE_W-1:0]           lim_reg;
    logic                          m_valid_reg, m_valid_next;
    logic [psp_pkg::M_TDATA_W-1:0] m_data_reg;

    logic [SIDE_W-1:0]         eff_side;
    logic                      s_acc, start, load_out;
    logic [NUM_W-1:0]          num, num_m1;
    logic                      oor;
    logic [NUMX_W-1:0]         num_x;
    logic [2:0]                q_bit;
    logic [ADDR_W-1:0]         q_raddr, b_raddr, raddr, waddr;
    logic                      we, prime;
    logic [psp_pkg::BYTE_W-1:0] wdata, rdata;
    psp_pkg::build_stat_t      b_stat;

    always_comb begin
        if (side_reg == '0) begin
            eff_side = SIDE_W'(1);
        end else if (32'(side_reg) > MAX_SIDE) begin
            eff_side = SIDE_W'(MAX_SIDE);
        end else begin
            eff_side = SIDE_W'(side_reg);
        end
    end

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == psp_pkg::T_IDLE) && ready_reg;
    assign s_acc     = s_tvalid && s_tready;
    assign load_out  = (state_reg == psp_pkg::T_LOOK) && (!m_valid_reg || m_tready);

    psp_cell_mapper #(
        .MAX_SIDE(MAX_SIDE)
    ) u_mapper (
        .aclk  (aclk),
        .load  (s_acc),
        .row   (s_tdata[7:0]),
        .column(s_tdata[15:8]),
        .side  (eff_side),
        .num   (num),
        .oor   (oor)
    );

    psp_sieve_builder #(
        .MAX_SIDE (MAX_SIDE),
        .RAM_DEPTH(RAM_DEPTH)
    ) u_builder (
        .aclk   (aclk),
        .aresetn(aresetn),
        .start  (start),
        .limit  (lim_reg),
        .stat   (b_stat),
        .we     (we),
        .waddr  (waddr),
        .wdata  (wdata),
        .raddr  (b_raddr),
        .rdata  (rdata)
    );

    psp_ram #(
        .WIDTH(psp_pkg::BYTE_W),
        .DEPTH(RAM_DEPTH)
    ) u_sieve (
        .aclk (aclk),
        .we   (we),
        .waddr(waddr),
        .wdata(wdata),
        .raddr(raddr),
        .rdata(rdata)
    );

    // odd k lives at bit ((k-1)/2)%8 of byte (k-1)/16
    assign num_m1  = num - NUM_W'(1);
    assign q_raddr = ADDR_W'(num_m1 >> 4);
    assign q_bit   = num_m1[3:1];
    assign raddr   = b_stat.busy ? b_raddr : q_raddr;
    assign num_x   = NUMX_W'(num);

    always_comb begin
        prime = 1'b0;
        if (!oor) begin
            if (num == NUM_W'(2)) begin
                prime = 1'b1;
            end else if (num[0] && (num <= NUM_W'(lim_reg))) begin
                prime = rdata[q_bit];
            end
        end
    end

    always_comb begin
        state_next = state_reg;
        ready_next = ready_reg;
        start      = 1'b0;
        unique case (state_reg)
            psp_pkg::T_IDLE: begin
                if (s_acc) begin
                    state_next = psp_pkg::T_MAP1;
                end else if (s_tvalid && !ready_reg) begin
                    start      = 1'b1;
                    state_next = psp_pkg::T_BUILD;
                end
            end
            psp_pkg::T_BUILD: begin
                if (b_stat.done) begin
                    ready_next = 1'b1;
                    state_next = psp_pkg::T_IDLE;
                end
            end
            psp_pkg::T_MAP1: state_next = psp_pkg::T_MAP2;
            psp_pkg::T_MAP2: state_next = psp_pkg::T_ADDR;
            psp_pkg::T_ADDR: state_next = psp_pkg::T_LOOK;
            psp_pkg::T_LOOK: begin
                if (load_out) begin
                    state_next = psp_pkg::T_IDLE;
                end
            end
            default: begin
                state_next = psp_pkg::T_IDLE;
            end
        endcase
        if (cfg_valid && cfg_ready) begin
            ready_next = 1'b0;
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (load_out) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= psp_pkg::T_IDLE;
            side_reg    <= psp_pkg::CFG_W'(1);
            ready_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            ready_reg   <= ready_next;
            m_valid_reg <= m_valid_next;
            if (cfg_valid && cfg_ready) begin
                side_reg <= cfg_data;
            end
        end
        lim_reg <= (2*SIDE_W)'(eff_side) * (2*SIDE_W)'(eff_side);
        if (load_out) begin
            m_data_reg <= {{PAD_W{1'b0}}, oor,
                           oor ? {psp_pkg::CELL_W{1'b0}} : num_x[psp_pkg::CELL_W-1:0],
                           prime};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule
`default_nettype wire
